FILE: hdl/assert_macros.svh
// Assertion helpers for the RTL files that include them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define CSAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Implication into the following cycle.
`define CSAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/csat_pkg.sv
package csat_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_FACES    = 128;
  localparam int MAX_EDGES    = 256;
  localparam int COORD_BITS   = 16;

  localparam int VtxAw   = $clog2(MAX_VERTICES);
  localparam int FaceAw  = $clog2(MAX_FACES);
  localparam int EdgeAw  = $clog2(MAX_EDGES);
  localparam int VCntW   = VtxAw + 1;
  localparam int FCntW   = FaceAw + 1;
  localparam int ECntW   = EdgeAw + 1;

  localparam int VtxW    = 3 * COORD_BITS;
  localparam int FaceW   = VtxAw + VtxW;
  localparam int EdgeW   = 2 * VtxAw;

  // Difference of two coordinates, cross product of two differences,
  // one dot-product term and the three-term sum.
  localparam int DiffW   = COORD_BITS + 1;
  localparam int CrossW  = 2 * DiffW + 1;
  localparam int ProdW   = CrossW + DiffW;
  localparam int AccW    = ProdW + 2;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = ECntW;

  typedef enum logic [2:0] {
    FN_VTX_A  = 3'd0,
    FN_VTX_B  = 3'd1,
    FN_FACE_A = 3'd2,
    FN_FACE_B = 3'd3,
    FN_EDGE_A = 3'd4,
    FN_EDGE_B = 3'd5,
    FN_RUN    = 3'd6
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_A_VCNT = 3'd0,
    REG_B_VCNT = 3'd1,
    REG_A_FCNT = 3'd2,
    REG_B_FCNT = 3'd3,
    REG_A_ECNT = 3'd4,
    REG_B_ECNT = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_clr;
    logic acc_sub;
  } mac_ctrl_t;

endpackage

FILE: hdl/csat_ram.sv
module csat_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/csat_mac.sv
module csat_mac (
  input  logic                                    clk_i,
  input  csat_pkg::mac_ctrl_t                     ctrl_i,
  input  logic signed [csat_pkg::CrossW-1:0]      op_a_i,
  input  logic signed [csat_pkg::DiffW-1:0]       op_b_i,
  output logic signed [csat_pkg::AccW-1:0]        acc_o
);
  import csat_pkg::*;

  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  base;
  logic signed [AccW-1:0]  prod_ext;

  // The product is registered before it reaches the adder.
  always_comb begin
    base     = ctrl_i.acc_clr ? '0 : acc_q;
    prod_ext = AccW'(prod_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= op_a_i * op_b_i;
    end
    if (ctrl_i.acc_en) begin
      acc_q <= ctrl_i.acc_sub ? base - prod_ext : base + prod_ext;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: hdl/convex_mesh_separating_axis_test.sv
// Separating axis overlap test for two convex meshes A and B.
// Input channel (valid/ready): each transfer carries func and its fields. Vertex,
// face and edge loads each write one store entry; a load
// whose slot lies beyond its store is dropped. A run transfer starts the test
// and the block holds in_ready_o low until the result is in the output register.
// Output channel (valid/ready): one intersect_res_o transfer per run, 1 when
// no separating axis exists. Loads give no output.
// A run tests the vertices of the other mesh against each face axis tried,
// then fetches each edge pair, forms its cross product and tests the vertices
// against that axis; it stops at the first separating axis. Run length is set
// by the single shared multiply-accumulate unit, which takes each product term
// in a multiply step and an accumulate step, and by the one read port per store.
// The configuration port takes the six counts at any time the block is idle.
// Reset clears the counts and the control state; store contents are undefined
// until loaded. While the receiver stalls the result is held in the output
// register and load transfers are still taken.
`include "assert_macros.svh"

module convex_mesh_separating_axis_test (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [csat_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [csat_pkg::CfgDataW-1:0]         cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [2:0]                            func_i,
  input  logic [7:0]                            slot_i,
  input  logic signed [15:0]                    coord_x_i,
  input  logic signed [15:0]                    coord_y_i,
  input  logic signed [15:0]                    coord_z_i,
  input  logic [5:0]                            face_ref_vertex_i,
  input  logic [5:0]                            edge_start_i,
  input  logic [5:0]                            edge_end_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  intersect_res_o
);
  import csat_pkg::*;

  typedef enum logic [21:0] {
    ST_IDLE     = 22'd1 << 0,
    ST_FACE_CHK = 22'd1 << 1,
    ST_FACE_REF = 22'd1 << 2,
    ST_FACE_P   = 22'd1 << 3,
    ST_SD_CHK   = 22'd1 << 4,
    ST_SD_Q     = 22'd1 << 5,
    ST_SD_MUL   = 22'd1 << 6,
    ST_SD_ACC   = 22'd1 << 7,
    ST_SD_SIGN  = 22'd1 << 8,
    ST_SD_END   = 22'd1 << 9,
    ST_EA_CHK   = 22'd1 << 10,
    ST_EA_S     = 22'd1 << 11,
    ST_EA_E     = 22'd1 << 12,
    ST_EA_V     = 22'd1 << 13,
    ST_EB_CHK   = 22'd1 << 14,
    ST_EB_S     = 22'd1 << 15,
    ST_EB_E     = 22'd1 << 16,
    ST_EB_V     = 22'd1 << 17,
    ST_CR_MUL   = 22'd1 << 18,
    ST_CR_ACC   = 22'd1 << 19,
    ST_CR_STORE = 22'd1 << 20,
    ST_DONE     = 22'd1 << 21
  } state_e;

  typedef enum logic [1:0] {
    PH_FACE_A,
    PH_FACE_B,
    PH_EDGE_A,
    PH_EDGE_B
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [VCntW-1:0] nva_cfg_q, nvb_cfg_q;
  logic [FCntW-1:0] nfa_cfg_q, nfb_cfg_q;
  logic [ECntW-1:0] nea_cfg_q, neb_cfg_q;
  logic [VCntW-1:0] nva, nvb;
  logic [FCntW-1:0] nfa, nfb;
  logic [ECntW-1:0] nea, neb;

  logic [ECntW-1:0] i_q, i_d;
  logic [ECntW-1:0] j_q, j_d;
  logic [VCntW-1:0] sd_j_q, sd_j_d, sd_n_q, sd_n_d;
  logic             sd_mesh_b_q, sd_mesh_b_d;
  logic             pos_q, pos_d, neg_q, neg_d, s0_pos_q, s0_pos_d;
  logic [2:0]       k_q, k_d;
  logic             res_q, res_d;
  logic             out_valid_q, out_valid_d, out_res_q, out_res_d;

  logic signed [CrossW-1:0]     d_q [3];
  logic signed [CrossW-1:0]     d_d [3];
  logic signed [COORD_BITS-1:0] p_q [3];
  logic signed [COORD_BITS-1:0] p_d [3];
  logic signed [COORD_BITS-1:0] vs_q [3];
  logic signed [COORD_BITS-1:0] vs_d [3];
  logic signed [DiffW-1:0]      q_q [3];
  logic signed [DiffW-1:0]      q_d [3];
  logic signed [DiffW-1:0]      ea_q [3];
  logic signed [DiffW-1:0]      ea_d [3];
  logic signed [DiffW-1:0]      eb_q [3];
  logic signed [DiffW-1:0]      eb_d [3];
  logic [VtxAw-1:0]             ee_q, ee_d;

  // Store ports.
  logic             acc_in;
  logic             we_va, we_vb, we_fa, we_fb, we_ea, we_eb;
  logic [VtxW-1:0]  vtx_wdata;
  logic [FaceW-1:0] face_wdata;
  logic [EdgeW-1:0] edge_wdata;
  logic [VtxAw-1:0] va_raddr, vb_raddr;
  logic [VtxW-1:0]  va_rdata, vb_rdata, sd_rdata;
  logic [FaceW-1:0] fa_rdata, fb_rdata, f_rdata;
  logic [EdgeW-1:0] eda_rdata, edb_rdata;

  logic signed [COORD_BITS-1:0] va_c [3];
  logic signed [COORD_BITS-1:0] vb_c [3];
  logic signed [COORD_BITS-1:0] sd_c [3];
  logic signed [COORD_BITS-1:0] fn_c [3];
  logic [VtxAw-1:0]             f_ref;

  mac_ctrl_t                mac_ctrl;
  logic signed [CrossW-1:0] op_a;
  logic signed [DiffW-1:0]  op_b;
  logic signed [AccW-1:0]   acc;

  // Counts above the store depth read as the depth.
  always_comb begin
    nva = (nva_cfg_q > VCntW'(MAX_VERTICES)) ? VCntW'(MAX_VERTICES) : nva_cfg_q;
    nvb = (nvb_cfg_q > VCntW'(MAX_VERTICES)) ? VCntW'(MAX_VERTICES) : nvb_cfg_q;
    nfa = (nfa_cfg_q > FCntW'(MAX_FACES)) ? FCntW'(MAX_FACES) : nfa_cfg_q;
    nfb = (nfb_cfg_q > FCntW'(MAX_FACES)) ? FCntW'(MAX_FACES) : nfb_cfg_q;
    nea = (nea_cfg_q > ECntW'(MAX_EDGES)) ? ECntW'(MAX_EDGES) : nea_cfg_q;
    neb = (neb_cfg_q > ECntW'(MAX_EDGES)) ? ECntW'(MAX_EDGES) : neb_cfg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nva_cfg_q <= '0;
      nvb_cfg_q <= '0;
      nfa_cfg_q <= '0;
      nfb_cfg_q <= '0;
      nea_cfg_q <= '0;
      neb_cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_A_VCNT: nva_cfg_q <= cfg_data_i[VCntW-1:0];
        REG_B_VCNT: nvb_cfg_q <= cfg_data_i[VCntW-1:0];
        REG_A_FCNT: nfa_cfg_q <= cfg_data_i[FCntW-1:0];
        REG_B_FCNT: nfb_cfg_q <= cfg_data_i[FCntW-1:0];
        REG_A_ECNT: nea_cfg_q <= cfg_data_i[ECntW-1:0];
        REG_B_ECNT: neb_cfg_q <= cfg_data_i[ECntW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc_in     = in_valid_i && in_ready_o;

  always_comb begin
    we_va = acc_in && (func_i == FN_VTX_A) && (int'(slot_i) < MAX_VERTICES);
    we_vb = acc_in && (func_i == FN_VTX_B) && (int'(slot_i) < MAX_VERTICES);
    we_fa = acc_in && (func_i == FN_FACE_A) && (int'(slot_i) < MAX_FACES);
    we_fb = acc_in && (func_i == FN_FACE_B) && (int'(slot_i) < MAX_FACES);
    we_ea = acc_in && (func_i == FN_EDGE_A) && (int'(slot_i) < MAX_EDGES);
    we_eb = acc_in && (func_i == FN_EDGE_B) && (int'(slot_i) < MAX_EDGES);
    vtx_wdata  = {coord_x_i[COORD_BITS-1:0], coord_y_i[COORD_BITS-1:0],
                  coord_z_i[COORD_BITS-1:0]};
    face_wdata = {face_ref_vertex_i[VtxAw-1:0], vtx_wdata};
    edge_wdata = {edge_start_i[VtxAw-1:0], edge_end_i[VtxAw-1:0]};
  end

  csat_ram #(.Width(VtxW), .Depth(MAX_VERTICES)) u_vtx_a (
    .clk_i, .we_i(we_va), .waddr_i(slot_i[VtxAw-1:0]), .wdata_i(vtx_wdata),
    .raddr_i(va_raddr), .rdata_o(va_rdata)
  );
  csat_ram #(.Width(VtxW), .Depth(MAX_VERTICES)) u_vtx_b (
    .clk_i, .we_i(we_vb), .waddr_i(slot_i[VtxAw-1:0]), .wdata_i(vtx_wdata),
    .raddr_i(vb_raddr), .rdata_o(vb_rdata)
  );
  csat_ram #(.Width(FaceW), .Depth(MAX_FACES)) u_face_a (
    .clk_i, .we_i(we_fa), .waddr_i(slot_i[FaceAw-1:0]), .wdata_i(face_wdata),
    .raddr_i(i_q[FaceAw-1:0]), .rdata_o(fa_rdata)
  );
  csat_ram #(.Width(FaceW), .Depth(MAX_FACES)) u_face_b (
    .clk_i, .we_i(we_fb), .waddr_i(slot_i[FaceAw-1:0]), .wdata_i(face_wdata),
    .raddr_i(i_q[FaceAw-1:0]), .rdata_o(fb_rdata)
  );
  csat_ram #(.Width(EdgeW), .Depth(MAX_EDGES)) u_edge_a (
    .clk_i, .we_i(we_ea), .waddr_i(slot_i[EdgeAw-1:0]), .wdata_i(edge_wdata),
    .raddr_i(i_q[EdgeAw-1:0]), .rdata_o(eda_rdata)
  );
  csat_ram #(.Width(EdgeW), .Depth(MAX_EDGES)) u_edge_b (
    .clk_i, .we_i(we_eb), .waddr_i(slot_i[EdgeAw-1:0]), .wdata_i(edge_wdata),
    .raddr_i(j_q[EdgeAw-1:0]), .rdata_o(edb_rdata)
  );

  always_comb begin
    f_rdata  = (phase_q == PH_FACE_A) ? fa_rdata : fb_rdata;
    sd_rdata = sd_mesh_b_q ? vb_rdata : va_rdata;
    f_ref    = f_rdata[FaceW-1 -: VtxAw];
    for (int c = 0; c < 3; c++) begin
      va_c[c] = va_rdata[VtxW-1-c*COORD_BITS -: COORD_BITS];
      vb_c[c] = vb_rdata[VtxW-1-c*COORD_BITS -: COORD_BITS];
      sd_c[c] = sd_rdata[VtxW-1-c*COORD_BITS -: COORD_BITS];
      fn_c[c] = f_rdata[VtxW-1-c*COORD_BITS -: COORD_BITS];
    end
  end

  // Vertex read addresses follow the sequencer step.
  always_comb begin
    va_raddr = sd_j_q[VtxAw-1:0];
    vb_raddr = sd_j_q[VtxAw-1:0];
    unique case (state_q)
      ST_FACE_REF: begin
        va_raddr = f_ref;
        vb_raddr = f_ref;
      end
      ST_EA_S:     va_raddr = eda_rdata[EdgeW-1 -: VtxAw];
      ST_EA_E:     va_raddr = ee_q;
      ST_EB_S:     vb_raddr = edb_rdata[EdgeW-1 -: VtxAw];
      ST_EB_E:     vb_raddr = ee_q;
      default: ;
    endcase
  end

  // Operands for the shared unit. The cross product runs six terms; odd
  // terms are subtracted from the even term before them.
  always_comb begin
    op_a = d_q[k_q[1:0]];
    op_b = q_q[k_q[1:0]];
    if (state_q == ST_CR_MUL) begin
      unique case (k_q)
        3'd0: begin op_a = CrossW'(ea_q[1]); op_b = eb_q[2]; end
        3'd1: begin op_a = CrossW'(ea_q[2]); op_b = eb_q[1]; end
        3'd2: begin op_a = CrossW'(ea_q[2]); op_b = eb_q[0]; end
        3'd3: begin op_a = CrossW'(ea_q[0]); op_b = eb_q[2]; end
        3'd4: begin op_a = CrossW'(ea_q[0]); op_b = eb_q[1]; end
        default: begin op_a = CrossW'(ea_q[1]); op_b = eb_q[0]; end
      endcase
    end
    mac_ctrl.mul_en  = (state_q == ST_SD_MUL) || (state_q == ST_CR_MUL);
    mac_ctrl.acc_en  = (state_q == ST_SD_ACC) || (state_q == ST_CR_ACC);
    mac_ctrl.acc_clr = (state_q == ST_SD_ACC) ? (k_q == 3'd0) : !k_q[0];
    mac_ctrl.acc_sub = (state_q == ST_CR_ACC) && k_q[0];
  end

  csat_mac u_mac (
    .clk_i,
    .ctrl_i(mac_ctrl),
    .op_a_i(op_a),
    .op_b_i(op_b),
    .acc_o (acc)
  );

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    i_d         = i_q;
    j_d         = j_q;
    sd_j_d      = sd_j_q;
    sd_n_d      = sd_n_q;
    sd_mesh_b_d = sd_mesh_b_q;
    pos_d       = pos_q;
    neg_d       = neg_q;
    s0_pos_d    = s0_pos_q;
    k_d         = k_q;
    res_d       = res_q;
    d_d         = d_q;
    p_d         = p_q;
    vs_d        = vs_q;
    q_d         = q_q;
    ea_d        = ea_q;
    eb_d        = eb_q;
    ee_d        = ee_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_res_d   = out_res_q;

    unique case (state_q)
      ST_IDLE: begin
        if (acc_in && (func_i == FN_RUN)) begin
          phase_d = PH_FACE_A;
          i_d     = '0;
          state_d = ST_FACE_CHK;
        end
      end
      ST_FACE_CHK: begin
        if ((phase_q == PH_FACE_A) && (i_q < ECntW'(nfa))) begin
          state_d = ST_FACE_REF;
        end else if ((phase_q == PH_FACE_B) && (i_q < ECntW'(nfb))) begin
          state_d = ST_FACE_REF;
        end else if (phase_q == PH_FACE_A) begin
          phase_d = PH_FACE_B;
          i_d     = '0;
        end else begin
          phase_d = PH_EDGE_A;
          i_d     = '0;
          state_d = ST_EA_CHK;
        end
      end
      ST_FACE_REF: begin
        for (int c = 0; c < 3; c++) d_d[c] = CrossW'(fn_c[c]);
        state_d = ST_FACE_P;
      end
      ST_FACE_P: begin
        // The reference point lies on the face's own mesh; test the other one.
        for (int c = 0; c < 3; c++) begin
          p_d[c] = (phase_q == PH_FACE_A) ? va_c[c] : vb_c[c];
        end
        sd_mesh_b_d = (phase_q == PH_FACE_A);
        sd_n_d      = (phase_q == PH_FACE_A) ? nvb : nva;
        sd_j_d      = '0;
        pos_d       = 1'b0;
        neg_d       = 1'b0;
        state_d     = ST_SD_CHK;
      end
      ST_SD_CHK: begin
        state_d = (sd_j_q < sd_n_q) ? ST_SD_Q : ST_SD_END;
      end
      ST_SD_Q: begin
        for (int c = 0; c < 3; c++) q_d[c] = DiffW'(sd_c[c]) - DiffW'(p_q[c]);
        k_d     = '0;
        state_d = ST_SD_MUL;
      end
      ST_SD_MUL: state_d = ST_SD_ACC;
      ST_SD_ACC: begin
        if (k_q == 3'd2) begin
          state_d = ST_SD_SIGN;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = ST_SD_MUL;
        end
      end
      ST_SD_SIGN: begin
        if (acc > 0) pos_d = 1'b1;
        if (acc < 0) neg_d = 1'b1;
        sd_j_d  = sd_j_q + VCntW'(1);
        state_d = ST_SD_CHK;
      end
      ST_SD_END: begin
        unique case (phase_q)
          PH_FACE_A, PH_FACE_B: begin
            if (pos_q && !neg_q) begin
              res_d   = 1'b0;
              state_d = ST_DONE;
            end else begin
              i_d     = i_q + ECntW'(1);
              state_d = ST_FACE_CHK;
            end
          end
          PH_EDGE_A: begin
            if (pos_q && neg_q) begin
              j_d     = j_q + ECntW'(1);
              state_d = ST_EB_CHK;
            end else begin
              s0_pos_d    = pos_q;
              sd_mesh_b_d = 1'b1;
              sd_n_d      = nvb;
              sd_j_d      = '0;
              pos_d       = 1'b0;
              neg_d       = 1'b0;
              phase_d     = PH_EDGE_B;
              state_d     = ST_SD_CHK;
            end
          end
          default: begin
            phase_d = PH_EDGE_A;
            if (!(pos_q && neg_q) && (s0_pos_q != pos_q)) begin
              res_d   = 1'b0;
              state_d = ST_DONE;
            end else begin
              j_d     = j_q + ECntW'(1);
              state_d = ST_EB_CHK;
            end
          end
        endcase
      end
      ST_EA_CHK: begin
        if (i_q < nea) begin
          state_d = ST_EA_S;
        end else begin
          res_d   = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_EA_S: begin
        ee_d    = eda_rdata[VtxAw-1:0];
        state_d = ST_EA_E;
      end
      ST_EA_E: begin
        p_d     = va_c;
        state_d = ST_EA_V;
      end
      ST_EA_V: begin
        for (int c = 0; c < 3; c++) ea_d[c] = DiffW'(p_q[c]) - DiffW'(va_c[c]);
        j_d     = '0;
        state_d = ST_EB_CHK;
      end
      ST_EB_CHK: begin
        if (j_q < neb) begin
          state_d = ST_EB_S;
        end else begin
          i_d     = i_q + ECntW'(1);
          state_d = ST_EA_CHK;
        end
      end
      ST_EB_S: begin
        ee_d    = edb_rdata[VtxAw-1:0];
        state_d = ST_EB_E;
      end
      ST_EB_E: begin
        vs_d    = vb_c;
        state_d = ST_EB_V;
      end
      ST_EB_V: begin
        for (int c = 0; c < 3; c++) eb_d[c] = DiffW'(vs_q[c]) - DiffW'(vb_c[c]);
        k_d     = '0;
        state_d = ST_CR_MUL;
      end
      ST_CR_MUL: state_d = ST_CR_ACC;
      ST_CR_ACC: begin
        if (k_q[0]) begin
          state_d = ST_CR_STORE;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = ST_CR_MUL;
        end
      end
      ST_CR_STORE: begin
        d_d[k_q[2:1]] = acc[CrossW-1:0];
        if (k_q == 3'd5) begin
          sd_mesh_b_d = 1'b0;
          sd_n_d      = nva;
          sd_j_d      = '0;
          pos_d       = 1'b0;
          neg_d       = 1'b0;
          state_d     = ST_SD_CHK;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = ST_CR_MUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FACE_A;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q         <= i_d;
    j_q         <= j_d;
    sd_j_q      <= sd_j_d;
    sd_n_q      <= sd_n_d;
    sd_mesh_b_q <= sd_mesh_b_d;
    pos_q       <= pos_d;
    neg_q       <= neg_d;
    s0_pos_q    <= s0_pos_d;
    k_q         <= k_d;
    res_q       <= res_d;
    d_q         <= d_d;
    p_q         <= p_d;
    vs_q        <= vs_d;
    q_q         <= q_d;
    ea_q        <= ea_d;
    eb_q        <= eb_d;
    ee_q        <= ee_d;
    out_res_q   <= out_res_d;
  end

  assign out_valid_o     = out_valid_q;
  assign intersect_res_o = out_res_q;

  `CSAT_ASSERT_NEXT(a_run_busy, in_valid_i && in_ready_o && func_i == FN_RUN, !in_ready_o,
    "run transfer did not make the block busy")
  `CSAT_ASSERT(a_res_from_done, $rose(out_valid_o) |-> $past(state_q == ST_DONE),
    "result appeared outside the done step")
  `CSAT_ASSERT(a_vtx_in_range, (state_q == ST_SD_Q) |-> (sd_j_q < sd_n_q),
    "side test read a vertex beyond the count")

endmodule

FILE: bench/csat_checker.sv
`timescale 1ns / 100ps

module csat_checker
  import csat_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [CfgDataW-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [2:0]              func_i,
  input  logic [7:0]              slot_i,
  input  logic signed [15:0]      coord_x_i,
  input  logic signed [15:0]      coord_y_i,
  input  logic signed [15:0]      coord_z_i,
  input  logic [5:0]              face_ref_vertex_i,
  input  logic [5:0]              edge_start_i,
  input  logic [5:0]              edge_end_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic                    intersect_res_i,
  output int                      errors_o,
  output int                      pending_o
);

  typedef struct {
    longint x;
    longint y;
    longint z;
  } point_t;

  point_t vtx_a[MAX_VERTICES];
  point_t vtx_b[MAX_VERTICES];
  point_t nrm_a[MAX_FACES];
  point_t nrm_b[MAX_FACES];
  int     fref_a[MAX_FACES];
  int     fref_b[MAX_FACES];
  int     estart_a[MAX_EDGES];
  int     eend_a[MAX_EDGES];
  int     estart_b[MAX_EDGES];
  int     eend_b[MAX_EDGES];
  int     counts[6];
  bit     overlap_q[$];

  function automatic point_t pt_sub(point_t a, point_t b);
    point_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic point_t pt_cross(point_t a, point_t b);
    point_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  // 0 when both signs are seen, 1 when only positive ones, -1 otherwise.
  function automatic int side_sign(bit of_b, int n, point_t d, point_t p);
    bit     pos;
    bit     neg;
    point_t q;
    longint t;
    pos = 0;
    neg = 0;
    for (int i = 0; i < n; i++) begin
      q = pt_sub(of_b ? vtx_b[i] : vtx_a[i], p);
      t = d.x * q.x + d.y * q.y + d.z * q.z;
      if (t > 0) pos = 1;
      else if (t < 0) neg = 1;
    end
    if (pos && neg) return 0;
    return pos ? 1 : -1;
  endfunction

  function automatic int clamp_to(int v, int depth);
    return (v > depth) ? depth : v;
  endfunction

  function automatic bit meshes_overlap();
    int     nva, nvb, nfa, nfb, nea, neb;
    int     sa, sb;
    point_t p, ea, eb, d;
    nva = clamp_to(counts[REG_A_VCNT], MAX_VERTICES);
    nvb = clamp_to(counts[REG_B_VCNT], MAX_VERTICES);
    nfa = clamp_to(counts[REG_A_FCNT], MAX_FACES);
    nfb = clamp_to(counts[REG_B_FCNT], MAX_FACES);
    nea = clamp_to(counts[REG_A_ECNT], MAX_EDGES);
    neb = clamp_to(counts[REG_B_ECNT], MAX_EDGES);
    for (int i = 0; i < nfa; i++)
      if (side_sign(1'b1, nvb, nrm_a[i], vtx_a[fref_a[i]]) > 0) return 0;
    for (int i = 0; i < nfb; i++)
      if (side_sign(1'b0, nva, nrm_b[i], vtx_b[fref_b[i]]) > 0) return 0;
    for (int i = 0; i < nea; i++) begin
      p  = vtx_a[estart_a[i]];
      ea = pt_sub(p, vtx_a[eend_a[i]]);
      for (int j = 0; j < neb; j++) begin
        eb = pt_sub(vtx_b[estart_b[j]], vtx_b[eend_b[j]]);
        d  = pt_cross(ea, eb);
        sa = side_sign(1'b0, nva, d, p);
        if (sa != 0) begin
          sb = side_sign(1'b1, nvb, d, p);
          if (sb != 0 && sa != sb) return 0;
        end
      end
    end
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    point_t v;
    bit     want;
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) counts[i] = 0;
      overlap_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_A_VCNT: counts[REG_A_VCNT] = int'(cfg_data_i[VCntW-1:0]);
          REG_B_VCNT: counts[REG_B_VCNT] = int'(cfg_data_i[VCntW-1:0]);
          REG_A_FCNT: counts[REG_A_FCNT] = int'(cfg_data_i[FCntW-1:0]);
          REG_B_FCNT: counts[REG_B_FCNT] = int'(cfg_data_i[FCntW-1:0]);
          REG_A_ECNT: counts[REG_A_ECNT] = int'(cfg_data_i[ECntW-1:0]);
          REG_B_ECNT: counts[REG_B_ECNT] = int'(cfg_data_i[ECntW-1:0]);
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        v.x = longint'(coord_x_i);
        v.y = longint'(coord_y_i);
        v.z = longint'(coord_z_i);
        case (func_i)
          FN_VTX_A: if (slot_i < MAX_VERTICES) vtx_a[slot_i] = v;
          FN_VTX_B: if (slot_i < MAX_VERTICES) vtx_b[slot_i] = v;
          FN_FACE_A: if (slot_i < MAX_FACES) begin
            nrm_a[slot_i]  = v;
            fref_a[slot_i] = int'(face_ref_vertex_i) % MAX_VERTICES;
          end
          FN_FACE_B: if (slot_i < MAX_FACES) begin
            nrm_b[slot_i]  = v;
            fref_b[slot_i] = int'(face_ref_vertex_i) % MAX_VERTICES;
          end
          FN_EDGE_A: begin
            estart_a[slot_i] = int'(edge_start_i) % MAX_VERTICES;
            eend_a[slot_i]   = int'(edge_end_i) % MAX_VERTICES;
          end
          FN_EDGE_B: begin
            estart_b[slot_i] = int'(edge_start_i) % MAX_VERTICES;
            eend_b[slot_i]   = int'(edge_end_i) % MAX_VERTICES;
          end
          FN_RUN: overlap_q.push_back(meshes_overlap());
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (overlap_q.size() == 0) begin
          $error("intersect_res: result transfer with nothing expected (actual %0d)",
                 intersect_res_i);
          errors_o++;
        end else begin
          want = overlap_q.pop_front();
          if (intersect_res_i !== want) begin
            $error("intersect_res: expected %0d, actual %0d", want, intersect_res_i);
            errors_o++;
          end
        end
      end
      pending_o = overlap_q.size();
    end
  end

endmodule

FILE: bench/tb_convex_mesh_separating_axis_test.sv
`timescale 1ns / 100ps

module tb_convex_mesh_separating_axis_test;
  import csat_pkg::*;

  localparam logic [2:0] FN_NONE = 3'd7;
  localparam int STALL_LIMIT = 100000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we;
  logic [CfgIdxW-1:0]     cfg_idx;
  logic [CfgDataW-1:0]    cfg_data;
  logic                   in_valid;
  logic                   in_ready_o;
  logic [2:0]             func_q;
  logic [7:0]             slot_q;
  logic signed [15:0]     cx_q, cy_q, cz_q;
  logic [5:0]             ref_q, es_q, ee_q;
  logic                   out_valid_o;
  logic                   out_ready;
  logic                   intersect_res_o;
  int                     errors;
  int                     pending;
  int                     send_idle_pct;
  int                     recv_stall_pct;
  int                     stuck_cycles;
  int                     tet_x[4], tet_y[4], tet_z[4];

  always #5 clk_i = ~clk_i;

  convex_mesh_separating_axis_test u_dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o,
    .func_i(func_q), .slot_i(slot_q),
    .coord_x_i(cx_q), .coord_y_i(cy_q), .coord_z_i(cz_q),
    .face_ref_vertex_i(ref_q), .edge_start_i(es_q), .edge_end_i(ee_q),
    .out_valid_o, .out_ready_i(out_ready), .intersect_res_o
  );

  csat_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready_o),
    .func_i(func_q), .slot_i(slot_q),
    .coord_x_i(cx_q), .coord_y_i(cy_q), .coord_z_i(cz_q),
    .face_ref_vertex_i(ref_q), .edge_start_i(es_q), .edge_end_i(ee_q),
    .out_valid_i(out_valid_o), .out_ready_i(out_ready),
    .intersect_res_i(intersect_res_o),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || cfg_we || !rst_ni) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("tb_convex_mesh_separating_axis_test: FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic int srand(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic send_item(logic [2:0] fn, int slot, int x, int y, int z,
                           int rv, int es, int ee);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    func_q   <= fn;
    slot_q   <= slot[7:0];
    cx_q     <= x[15:0];
    cy_q     <= y[15:0];
    cz_q     <= z[15:0];
    ref_q    <= rv[5:0];
    es_q     <= es[5:0];
    ee_q     <= ee[5:0];
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  task automatic run_test();
    send_item(FN_RUN, $urandom_range(255), $urandom, $urandom, $urandom,
              $urandom_range(63), $urandom_range(63), $urandom_range(63));
  endtask

  // Hold off the sender until every result is back and the block has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_counts(int va, int vb, int fa, int fb, int ea, int eb);
    int vals[6];
    vals = '{va, vb, fa, fb, ea, eb};
    wait_idle();
    for (int i = 0; i < 6; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= reg_idx_e'(i);
      cfg_data <= vals[i][CfgDataW-1:0];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // Random non-degenerate tetrahedron around a centre point.
  task automatic make_tetra(int cx, int cy, int cz, int sz);
    int ux, uy, uz, vx, vy, vz, wx, wy, wz, vol;
    do begin
      for (int i = 0; i < 4; i++) begin
        tet_x[i] = cx + srand(-sz, sz);
        tet_y[i] = cy + srand(-sz, sz);
        tet_z[i] = cz + srand(-sz, sz);
      end
      ux = tet_x[1] - tet_x[0]; uy = tet_y[1] - tet_y[0]; uz = tet_z[1] - tet_z[0];
      vx = tet_x[2] - tet_x[0]; vy = tet_y[2] - tet_y[0]; vz = tet_z[2] - tet_z[0];
      wx = tet_x[3] - tet_x[0]; wy = tet_y[3] - tet_y[0]; wz = tet_z[3] - tet_z[0];
      vol = ux * (vy * wz - vz * wy) - uy * (vx * wz - vz * wx) + uz * (vx * wy - vy * wx);
    end while (vol == 0);
  endtask

  // Loads the current tetrahedron, shifted, as mesh A or B; normals point outward.
  task automatic load_tetra(bit to_b, int nf, int ne, int sx, int sy, int sz);
    int ea[6], eb[6];
    int i, j, l, ux, uy, uz, vx, vy, vz, nx, ny, nz, t;
    ea = '{0, 0, 0, 1, 1, 2};
    eb = '{1, 2, 3, 2, 3, 3};
    for (int k = 0; k < 4; k++)
      send_item(to_b ? FN_VTX_B : FN_VTX_A, k, tet_x[k] + sx, tet_y[k] + sy,
                tet_z[k] + sz, 0, 0, 0);
    for (int k = 0; k < nf; k++) begin
      i = (k + 1) % 4; j = (k + 2) % 4; l = (k + 3) % 4;
      ux = tet_x[j] - tet_x[i]; uy = tet_y[j] - tet_y[i]; uz = tet_z[j] - tet_z[i];
      vx = tet_x[l] - tet_x[i]; vy = tet_y[l] - tet_y[i]; vz = tet_z[l] - tet_z[i];
      nx = uy * vz - uz * vy;
      ny = uz * vx - ux * vz;
      nz = ux * vy - uy * vx;
      t = nx * (tet_x[k] - tet_x[i]) + ny * (tet_y[k] - tet_y[i]) + nz * (tet_z[k] - tet_z[i]);
      if (t > 0) begin
        nx = -nx; ny = -ny; nz = -nz;
      end
      send_item(to_b ? FN_FACE_B : FN_FACE_A, k, nx, ny, nz, i, 0, 0);
    end
    for (int k = 0; k < ne; k++) begin
      if ($urandom_range(1))
        send_item(to_b ? FN_EDGE_B : FN_EDGE_A, k, 0, 0, 0, 0, ea[k], eb[k]);
      else
        send_item(to_b ? FN_EDGE_B : FN_EDGE_A, k, 0, 0, 0, 0, eb[k], ea[k]);
    end
  endtask

  // Largest stores in use: A clustered at the origin, B far along +x. The first
  // face normal of A points firmly along +x, so that axis separates straight away
  // and no face or edge beyond the first is ever read.
  task automatic extreme_scene();
    set_counts(64, 64, 128, 128, 256, 256);
    for (int k = 0; k < MAX_VERTICES; k++) begin
      send_item(FN_VTX_A, k, srand(-100, 100), srand(-100, 100), srand(-100, 100), 0, 0, 0);
      send_item(FN_VTX_B, k, srand(1000, 1200), srand(-400, 400), srand(-400, 400), 0, 0, 0);
    end
    send_item(FN_FACE_A, 0, srand(4, 32767), srand(-3, 3), srand(-3, 3),
              $urandom_range(63), 0, 0);
    send_item(FN_EDGE_A, 0, 0, 0, 0, 0, $urandom_range(63), $urandom_range(63));
    send_item(FN_EDGE_B, 0, 0, 0, 0, 0, $urandom_range(63), $urandom_range(63));
    run_test();
    // Counts above the store depth, only one edge pair as axis.
    set_counts(127, 127, 0, 0, 1, 1);
    run_test();
    set_counts(127, 127, 255, 255, 511, 511);
    run_test();
  endtask

  task automatic random_scene(int n);
    int nfa, nfb, nea, neb;
    case (n % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
      default: begin send_idle_pct = 15; recv_stall_pct = 15; end
    endcase
    nfa = srand(1, 4); nfb = srand(1, 4);
    nea = srand(1, 6); neb = srand(1, 6);
    set_counts(4, 4, nfa, nfb, nea, neb);
    make_tetra(0, 0, 0, srand(30, 60));
    load_tetra(1'b0, nfa, nea, 0, 0, 0);
    make_tetra(srand(-150, 150), srand(-150, 150), srand(-150, 150), srand(30, 60));
    load_tetra(1'b1, nfb, neb, 0, 0, 0);
    repeat (srand(1, 3)) begin
      run_test();
      case ($urandom_range(3))
        0: send_item(FN_NONE, $urandom_range(255), $urandom, $urandom, $urandom,
                     $urandom_range(63), $urandom_range(63), $urandom_range(63));
        1: send_item($urandom_range(1) ? FN_VTX_A : FN_VTX_B, srand(64, 255),
                     $urandom, $urandom, $urandom, 0, 0, 0);
        2: send_item($urandom_range(1) ? FN_VTX_A : FN_VTX_B, $urandom_range(3),
                     $urandom, $urandom, $urandom, 0, 0, 0);
        default: ;
      endcase
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    func_q         = FN_VTX_A;
    slot_q         = '0;
    cx_q           = '0;
    cy_q           = '0;
    cz_q           = '0;
    ref_q          = '0;
    es_q           = '0;
    ee_q           = '0;
    out_ready      = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stuck_cycles   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty meshes overlap; loads at the field extremes, dropped slots, unknown func.
    set_counts(0, 0, 0, 0, 0, 0);
    run_test();
    send_item(FN_NONE, 255, -32768, 32767, -1, 63, 63, 63);
    send_item(FN_VTX_A, 0, -32768, 32767, -1, 0, 0, 0);
    send_item(FN_VTX_B, 63, 32767, -32768, 0, 0, 0, 0);
    send_item(FN_FACE_A, 127, 32767, -32768, 1, 0, 0, 0);
    send_item(FN_FACE_B, 0, -32768, -32768, 32767, 63, 0, 0);
    send_item(FN_EDGE_A, 255, 0, 0, 0, 0, 63, 0);
    send_item(FN_EDGE_B, 0, 0, 0, 0, 0, 0, 63);
    send_item(FN_VTX_A, 64, 1, 2, 3, 0, 0, 0);
    send_item(FN_VTX_B, 255, 1, 2, 3, 0, 0, 0);
    send_item(FN_FACE_A, 128, 1, 2, 3, 5, 0, 0);
    send_item(FN_FACE_B, 200, 1, 2, 3, 5, 0, 0);
    run_test();

    // Translated copies: every edge of A parallel to one of B.
    set_counts(4, 4, 4, 4, 6, 6);
    make_tetra(0, 0, 0, 50);
    load_tetra(1'b0, 4, 6, 0, 0, 0);
    load_tetra(1'b1, 4, 6, 20, -10, 5);
    run_test();
    load_tetra(1'b1, 4, 6, 300, 0, 0);
    run_test();
    set_counts(4, 4, 0, 0, 6, 6);
    run_test();

    extreme_scene();

    for (int n = 0; n < 15; n++) random_scene(n);

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb_convex_mesh_separating_axis_test: PASS");
    end else begin
      $display("tb_convex_mesh_separating_axis_test: FAIL");
    end
    $finish;
  end

endmodule
